>>> hw/rtl/cmask_pkg.sv
package cmask_pkg;

    localparam int CHAR_BITS = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CHAR_BITS-1:0] CH_MASK      = CHAR_BITS'('h01);
    localparam logic [CHAR_BITS-1:0] CH_SPACE     = CHAR_BITS'('h20);
    localparam logic [CHAR_BITS-1:0] CH_SLASH     = CHAR_BITS'('h2F);
    localparam logic [CHAR_BITS-1:0] CH_STAR      = CHAR_BITS'('h2A);
    localparam logic [CHAR_BITS-1:0] CH_QUOTE     = CHAR_BITS'('h22);
    localparam logic [CHAR_BITS-1:0] CH_BACKSLASH = CHAR_BITS'('h5C);
    localparam logic [CHAR_BITS-1:0] CH_LF        = CHAR_BITS'('h0A);
    localparam logic [CHAR_BITS-1:0] CH_CR        = CHAR_BITS'('h0D);

    typedef enum logic [1:0] {
        MODE_CODE   = 2'd0,
        MODE_LINE   = 2'd1,
        MODE_BLOCK  = 2'd2,
        MODE_STRING = 2'd3
    } mode_t;

    typedef struct packed {
        logic [CHAR_BITS-1:0] ch;
        logic                 last;
    } item_t;

    // Up to two result characters produced by one input transfer.
    typedef struct packed {
        logic [1:0] cnt;
        item_t      first;
        item_t      second;
    } push_t;

    typedef struct packed {
        logic  held_valid;
        mode_t mode;
    } lex_status_t;

    typedef struct packed {
        logic [CHAR_BITS-1:0] oc;
        mode_t                mode;
        logic                 esc;
        logic                 consumed;
    } step_t;

    function automatic logic is_newline(input logic [CHAR_BITS-1:0] c);
        return (c == CH_LF) || (c == CH_CR);
    endfunction

    // One lexer step on character c, with an optional lookahead character nx.
    function automatic step_t lex_step(input mode_t mode, input logic esc,
                                       input logic [CHAR_BITS-1:0] c,
                                       input logic has_next,
                                       input logic [CHAR_BITS-1:0] nx);
        step_t r;
        r.oc = c;
        r.mode = mode;
        r.esc = esc;
        r.consumed = 1'b0;
        case (mode)
            MODE_LINE: begin
                if (is_newline(c)) begin
                    r.mode = MODE_CODE;
                end else begin
                    r.oc = CH_MASK;
                end
            end
            MODE_BLOCK: begin
                if (c == CH_STAR && has_next && nx == CH_SLASH) begin
                    r.oc = CH_MASK;
                    r.mode = MODE_CODE;
                    r.consumed = 1'b1;
                end else if (!is_newline(c)) begin
                    r.oc = CH_MASK;
                end
            end
            MODE_STRING: begin
                if (is_newline(c)) begin
                    r.mode = MODE_CODE;
                end else begin
                    r.oc = CH_SPACE;
                end
                if (esc) begin
                    r.esc = 1'b0;
                end else if (c == CH_BACKSLASH) begin
                    r.esc = 1'b1;
                end else if (c == CH_QUOTE) begin
                    r.mode = MODE_CODE;
                end
            end
            default: begin
                if (c == CH_SLASH && has_next && nx == CH_SLASH) begin
                    r.oc = CH_MASK;
                    r.mode = MODE_LINE;
                    r.consumed = 1'b1;
                end else if (c == CH_SLASH && has_next && nx == CH_STAR) begin
                    r.oc = CH_MASK;
                    r.mode = MODE_BLOCK;
                    r.consumed = 1'b1;
                end else if (c == CH_QUOTE) begin
                    r.oc = CH_MASK;
                    r.mode = MODE_STRING;
                    r.esc = 1'b0;
                end
            end
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/cmask_lexer.sv
module cmask_lexer
    import cmask_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_fire,
    input  logic [CHAR_BITS-1:0] in_char,
    input  logic                 in_last,
    output push_t                push,
    output lex_status_t          status
);

    logic [CHAR_BITS-1:0] held_char_reg, held_char_next;
    logic                 held_valid_reg, held_valid_next;
    mode_t                mode_reg, mode_next;
    logic                 esc_reg, esc_next;

    step_t held_step;
    step_t new_step;
    mode_t mid_mode;
    logic  mid_esc;
    logic  pending;

    always_comb begin
        held_step = lex_step(mode_reg, esc_reg, held_char_reg, 1'b1, in_char);
        mid_mode = held_valid_reg ? held_step.mode : mode_reg;
        mid_esc = held_valid_reg ? held_step.esc : esc_reg;
        new_step = lex_step(mid_mode, mid_esc, in_char, 1'b0, '0);
        pending = !(held_valid_reg && held_step.consumed);

        push.cnt = 2'd0;
        push.first = '0;
        push.second = '0;
        held_char_next = held_char_reg;
        held_valid_next = held_valid_reg;
        mode_next = mode_reg;
        esc_next = esc_reg;

        if (in_fire) begin
            mode_next = mid_mode;
            esc_next = mid_esc;
            held_valid_next = 1'b0;
            if (held_valid_reg) begin
                push.first.ch = held_step.oc;
                push.first.last = 1'b0;
                push.cnt = 2'd1;
                if (held_step.consumed) begin
                    // The new character closes the pair and goes out masked.
                    push.second.ch = CH_MASK;
                    push.second.last = in_last;
                    push.cnt = 2'd2;
                end
            end
            if (pending) begin
                if (in_last) begin
                    if (held_valid_reg) begin
                        push.second.ch = new_step.oc;
                        push.second.last = 1'b1;
                        push.cnt = 2'd2;
                    end else begin
                        push.first.ch = new_step.oc;
                        push.first.last = 1'b1;
                        push.cnt = 2'd1;
                    end
                end else begin
                    held_char_next = in_char;
                    held_valid_next = 1'b1;
                end
            end
            if (in_last) begin
                held_valid_next = 1'b0;
                mode_next = MODE_CODE;
                esc_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg <= 1'b0;
            mode_reg <= MODE_CODE;
            esc_reg <= 1'b0;
        end else begin
            held_valid_reg <= held_valid_next;
            mode_reg <= mode_next;
            esc_reg <= esc_next;
        end
        held_char_reg <= held_char_next;
    end

    assign status.held_valid = held_valid_reg;
    assign status.mode = mode_reg;

endmodule

>>> hw/rtl/cmask_out_queue.sv
module cmask_out_queue
    import cmask_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  push_t                 push,
    input  logic                  pop,
    output item_t                 head,
    output logic                  head_valid,
    output logic                  has_room,
    output logic [COUNT_BITS-1:0] count
);

    item_t                 q_reg [QUEUE_DEPTH];
    item_t                 q_next [QUEUE_DEPTH];
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [COUNT_BITS-1:0] base;

    always_comb begin
        base = count_reg - COUNT_BITS'(pop);
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (pop && i < QUEUE_DEPTH - 1) begin
                q_next[i] = q_reg[(i + 1) % QUEUE_DEPTH];
            end else begin
                q_next[i] = q_reg[i];
            end
            if (push.cnt != 2'd0 && COUNT_BITS'(i) == base) begin
                q_next[i] = push.first;
            end
            if (push.cnt == 2'd2 && COUNT_BITS'(i) == base + COUNT_BITS'(1)) begin
                q_next[i] = push.second;
            end
        end
        count_next = base + COUNT_BITS'(push.cnt);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

    assign head = q_reg[0];
    assign head_valid = (count_reg != '0);
    // Room for a full two-character burst is required before a transfer.
    assign has_room = (count_reg <= COUNT_BITS'(QUEUE_DEPTH - 2));
    assign count = count_reg;

endmodule

>>> hw/rtl/comment_string_masker.sv
// Each character enters the output queue on the transfer of the character that follows it
// (or on its own transfer when it is flagged last); results come from a 4-entry output queue.
// Throughput: one input transfer per cycle while the queue has room for two results; a
// pair or a final flush can give two results, drained at one output per cycle while m_tready is high.
// Reset (aresetn low, synchronous): lexer returns to code mode, nothing held, queue empty.
module comment_string_masker
    import cmask_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] in_char
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] out_char
    output logic        m_tlast
);

    logic                  in_fire;
    push_t                 push;
    lex_status_t           status;
    item_t                 head;
    logic                  head_valid;
    logic                  has_room;
    logic [COUNT_BITS-1:0] count;

    assign s_tready = has_room;
    assign in_fire = s_tvalid && s_tready;

    cmask_lexer u_lexer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .in_char (s_tdata[CHAR_BITS-1:0]),
        .in_last (s_tlast),
        .push    (push),
        .status  (status)
    );

    cmask_out_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .pop        (m_tvalid && m_tready),
        .head       (head),
        .head_valid (head_valid),
        .has_room   (has_room),
        .count      (count)
    );

    assign m_tvalid = head_valid;
    assign m_tdata = head.ch;
    assign m_tlast = head.last;

    assert property (@(posedge aclk) disable iff (!aresetn)
        count <= COUNT_BITS'(QUEUE_DEPTH))
        else $error("output queue overflow");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_tlast) |=> (!status.held_valid && status.mode == MODE_CODE))
        else $error("lexer state not cleared after last transfer");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && !status.held_valid && !s_tlast) |-> (push.cnt == 2'd0))
        else $error("result produced without a held character");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_tlast) |-> (push.cnt != 2'd0))
        else $error("last transfer produced no result");

endmodule

>>> bench/comment_string_masker_tb.sv
`timescale 1ns / 100ps

module comment_string_masker_tb;
    import cmask_pkg::*;

    localparam int LONG_STALL = 300;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [15:0] in_char
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [15:0] out_char
    logic        m_tlast;

    // Predictor state, mirroring the lexer inside the block.
    logic [15:0] held_ch;
    logic        held_ok;
    mode_t       text_mode;
    logic        in_escape;

    item_t masked_q[$];
    int    mismatches;
    bit    src_idle_on;
    bit    snk_idle_on;
    int    stall_requests;
    int    stalls_done;

    comment_string_masker i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    function automatic int idle_len(input bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end else begin
            return $urandom_range(8, 30);
        end
    endfunction

    // Masks one character of the text, with an optional lookahead character.
    // Returns 1 when the lookahead was swallowed as the second half of a pair.
    function automatic logic mask_one(input logic [15:0] c, input logic has_next,
                                      input logic [15:0] nx, output logic [15:0] oc);
        logic nl;
        nl = (c == CH_LF) || (c == CH_CR);
        oc = c;
        mask_one = 1'b0;
        case (text_mode)
            MODE_LINE: begin
                if (nl) begin
                    text_mode = MODE_CODE;
                end else begin
                    oc = CH_MASK;
                end
            end
            MODE_BLOCK: begin
                if (c == CH_STAR && has_next && nx == CH_SLASH) begin
                    oc = CH_MASK;
                    text_mode = MODE_CODE;
                    mask_one = 1'b1;
                end else if (!nl) begin
                    oc = CH_MASK;
                end
            end
            MODE_STRING: begin
                if (nl) begin
                    text_mode = MODE_CODE;
                end else begin
                    oc = CH_SPACE;
                end
                if (in_escape) begin
                    in_escape = 1'b0;
                end else if (c == CH_BACKSLASH) begin
                    in_escape = 1'b1;
                end else if (c == CH_QUOTE) begin
                    text_mode = MODE_CODE;
                end
            end
            default: begin
                if (c == CH_SLASH && has_next && (nx == CH_SLASH || nx == CH_STAR)) begin
                    oc = CH_MASK;
                    text_mode = (nx == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
                    mask_one = 1'b1;
                end else if (c == CH_QUOTE) begin
                    oc = CH_MASK;
                    text_mode = MODE_STRING;
                    in_escape = 1'b0;
                end
            end
        endcase
    endfunction

    function automatic void clear_lexer();
        held_ch = '0;
        held_ok = 1'b0;
        text_mode = MODE_CODE;
        in_escape = 1'b0;
    endfunction

    task automatic predict_masked(input logic [15:0] c, input logic last);
        logic [15:0] oc;
        logic        took_pair;
        logic        still_open;
        still_open = 1'b1;
        if (held_ok) begin
            took_pair = mask_one(held_ch, 1'b1, c, oc);
            masked_q.push_back('{ch: oc, last: 1'b0});
            held_ok = 1'b0;
            held_ch = '0;
            if (took_pair) begin
                masked_q.push_back('{ch: CH_MASK, last: last});
                still_open = 1'b0;
            end
        end
        if (still_open) begin
            if (last) begin
                took_pair = mask_one(c, 1'b0, '0, oc);
                masked_q.push_back('{ch: oc, last: 1'b1});
            end else begin
                held_ch = c;
                held_ok = 1'b1;
            end
        end
        if (last) begin
            clear_lexer();
        end
    endtask

    // Watches both channels: results are checked before the transfer of the same
    // edge is predicted, which is safe since a result never leaves in the cycle
    // of its own input.
    always @(posedge aclk) begin
        item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (masked_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: unexpected output char=%h last=%b", $realtime,
                             m_tdata, m_tlast);
                end
            end else begin
                want = masked_q.pop_front();
                if (m_tdata !== want.ch || m_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: mismatch char exp=%h got=%h last exp=%b got=%b",
                                 $realtime, want.ch, m_tdata, want.last, m_tlast);
                    end
                end
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            predict_masked(s_tdata, s_tlast);
        end
    end

    // Output side: ready in short bursts with random gaps, and a long hold-off
    // whenever a test asks for one.
    initial begin
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (stall_requests != stalls_done) begin
                m_tready <= 1'b0;
                repeat (LONG_STALL) @(posedge aclk);
                stalls_done++;
            end else begin
                int gap;
                gap = idle_len(snk_idle_on);
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    end

    // Returns at the edge where the character is transferred, with tvalid still high.
    task automatic send_char(input logic [15:0] ch, input logic last);
        int gap;
        gap = idle_len(src_idle_on);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata <= 16'($urandom);
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= ch;
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_char(16'(s[i]), i == s.len() - 1);
        end
    endtask

    function automatic logic [15:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 18) return CH_SLASH;
        if (r < 30) return CH_STAR;
        if (r < 42) return CH_QUOTE;
        if (r < 50) return CH_BACKSLASH;
        if (r < 58) return CH_LF;
        if (r < 62) return CH_CR;
        if (r < 67) return CH_SPACE;
        if (r < 90) return 16'($urandom_range(8'h61, 8'h7A));
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    task automatic send_random_texts(input int n_chars, input int max_len);
        int left;
        int len;
        left = n_chars;
        while (left > 0) begin
            len = $urandom_range(1, max_len);
            if (len > left) begin
                len = left;
            end
            for (int i = 0; i < len; i++) begin
                send_char(pick_char(), i == len - 1);
            end
            left -= len;
        end
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (masked_q.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed();
        // Extreme codes as a two-character text.
        send_char(16'h0000, 1'b0);
        send_char(16'hFFFF, 1'b1);
        // Line comment, block comment across a CR, string with an escaped quote,
        // a string ended by a newline, and a slash at the very end.
        send_text("//x\n/*\015*/\"\\\"y\"\"\n/");
        // Comment opener split by the final character, then an open string.
        send_text("/*");
        send_text("\"a");
        send_text("/");
    endtask

    task automatic test_random_text();
        send_random_texts(1150, 40);
    endtask

    task automatic test_back_to_back();
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        send_random_texts(200, 25);
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
    endtask

    task automatic test_output_backpressure();
        src_idle_on = 1'b0;
        stall_requests++;
        send_random_texts(80, 30);
        src_idle_on = 1'b1;
        wait_for_results();
    endtask

    initial begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        clear_lexer();
        mismatches = 0;
        stall_requests = 0;
        stalls_done = 0;
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tlast <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_random_text();
        test_back_to_back();
        test_output_backpressure();
        send_random_texts(150, 40);

        wait_for_results();
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && masked_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
